### rtl/cbag_pkg.sv
// ----------------------------------------------------------------------------
// cbag_pkg
// Shared types, constants and square-stepping functions for the chess
// attack generator: piece kinds, ray directions and the pipeline item.
// ----------------------------------------------------------------------------
package cbag_pkg;

  localparam int SQ_W      = 6;
  localparam int BOARD_W   = 64;
  localparam int NUM_DIRS  = 8;
  // longest ray on the board is seven squares, one cell per square
  localparam int NUM_CELLS = 7;

  typedef enum logic [2:0] {
    MODE_WPAWN  = 3'd0,
    MODE_BPAWN  = 3'd1,
    MODE_KNIGHT = 3'd2,
    MODE_KING   = 3'd3,
    MODE_BISHOP = 3'd4,
    MODE_ROOK   = 3'd5,
    MODE_QUEEN  = 3'd6,
    MODE_NONE   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    DIR_N  = 3'd0,
    DIR_S  = 3'd1,
    DIR_E  = 3'd2,
    DIR_W  = 3'd3,
    DIR_NE = 3'd4,
    DIR_NW = 3'd5,
    DIR_SE = 3'd6,
    DIR_SW = 3'd7
  } dir_t;

  typedef struct packed {
    logic                               ok;
    logic [SQ_W-1:0]                    sq;
  } step_t;

  typedef struct packed {
    logic                               valid;
    logic [BOARD_W-1:0]                 occ;
    logic [BOARD_W-1:0]                 attacks;
    logic [NUM_DIRS-1:0]                act;
    logic [NUM_DIRS-1:0][SQ_W-1:0]      pos;
  } item_t;

  // one step along a ray, ok low when it would leave the board
  function automatic step_t step_sq(input logic [SQ_W-1:0] sq, input dir_t dir);
    step_t       s;
    logic [2:0]  r;
    logic [2:0]  f;
    r = sq[5:3];
    f = sq[2:0];
    case (dir)
      DIR_N: begin
        s.ok = (r != 3'd7);
        s.sq = sq + 6'd8;
      end
      DIR_S: begin
        s.ok = (r != 3'd0);
        s.sq = sq - 6'd8;
      end
      DIR_E: begin
        s.ok = (f != 3'd7);
        s.sq = sq + 6'd1;
      end
      DIR_W: begin
        s.ok = (f != 3'd0);
        s.sq = sq - 6'd1;
      end
      DIR_NE: begin
        s.ok = (r != 3'd7) && (f != 3'd7);
        s.sq = sq + 6'd9;
      end
      DIR_NW: begin
        s.ok = (r != 3'd7) && (f != 3'd0);
        s.sq = sq + 6'd7;
      end
      DIR_SE: begin
        s.ok = (r != 3'd0) && (f != 3'd7);
        s.sq = sq - 6'd7;
      end
      DIR_SW: begin
        s.ok = (r != 3'd0) && (f != 3'd0);
        s.sq = sq - 6'd9;
      end
      default: begin
        s.ok = 1'b0;
        s.sq = sq;
      end
    endcase
    return s;
  endfunction

  // attack set of the leaping pieces, zero for sliders and the unused kind
  function automatic logic [BOARD_W-1:0] leap_set(input mode_t mode,
                                                  input logic [SQ_W-1:0] sq);
    logic [BOARD_W-1:0] set;
    int                 r;
    int                 f;
    int                 nr;
    int                 nf;
    int                 dr [8];
    int                 df [8];
    int                 n;
    set = '0;
    r   = int'(sq[5:3]);
    f   = int'(sq[2:0]);
    n   = 0;
    dr  = '{0, 0, 0, 0, 0, 0, 0, 0};
    df  = '{0, 0, 0, 0, 0, 0, 0, 0};
    case (mode)
      MODE_WPAWN: begin
        dr = '{-1, -1, 0, 0, 0, 0, 0, 0};
        df = '{1, -1, 0, 0, 0, 0, 0, 0};
        n  = 2;
      end
      MODE_BPAWN: begin
        dr = '{1, 1, 0, 0, 0, 0, 0, 0};
        df = '{1, -1, 0, 0, 0, 0, 0, 0};
        n  = 2;
      end
      MODE_KNIGHT: begin
        dr = '{1, 1, -1, -1, 2, 2, -2, -2};
        df = '{2, -2, 2, -2, 1, -1, 1, -1};
        n  = 8;
      end
      MODE_KING: begin
        dr = '{1, 1, 1, 0, 0, -1, -1, -1};
        df = '{-1, 0, 1, -1, 1, -1, 0, 1};
        n  = 8;
      end
      default: n = 0;
    endcase
    for (int i = 0; i < 8; i++) begin
      nr = r + dr[i];
      nf = f + df[i];
      if ((i < n) && (nr >= 0) && (nr <= 7) && (nf >= 0) && (nf <= 7)) begin
        set[6'(nr * 8 + nf)] = 1'b1;
      end
    end
    return set;
  endfunction

endpackage

### rtl/cbag_entry.sv
// ----------------------------------------------------------------------------
// cbag_entry
// Head of the cell chain: registers a query, fills in the leaper set and
// launches one ray frontier per sliding direction the piece uses.
// ----------------------------------------------------------------------------
module cbag_entry (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  logic [2:0]                       mode,
  input  logic [cbag_pkg::SQ_W-1:0]        square,
  input  logic [cbag_pkg::BOARD_W-1:0]     occupancy,
  output cbag_pkg::item_t                  item
);

  cbag_pkg::item_t item_next;
  cbag_pkg::mode_t kind;
  cbag_pkg::step_t first;
  logic            rook_en;
  logic            bish_en;

  always_comb begin
    kind    = cbag_pkg::mode_t'(mode);
    rook_en = (kind == cbag_pkg::MODE_ROOK) || (kind == cbag_pkg::MODE_QUEEN);
    bish_en = (kind == cbag_pkg::MODE_BISHOP) || (kind == cbag_pkg::MODE_QUEEN);
    item_next.valid   = load;
    item_next.occ     = occupancy;
    item_next.attacks = cbag_pkg::leap_set(kind, square);
    first             = '0;
    for (int d = 0; d < cbag_pkg::NUM_DIRS; d++) begin
      first = cbag_pkg::step_sq(square, cbag_pkg::dir_t'(3'(d)));
      // orthogonal directions sit in the low half
      item_next.act[d] = first.ok && ((d < 4) ? rook_en : bish_en);
      item_next.pos[d] = first.sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item.valid <= item_next.valid;
    end
    item.occ     <= item_next.occ;
    item.attacks <= item_next.attacks;
    item.act     <= item_next.act;
    item.pos     <= item_next.pos;
  end

endmodule

### rtl/cbag_ray_cell.sv
// ----------------------------------------------------------------------------
// cbag_ray_cell
// One link of the chain: every live ray claims its current square, stops on
// an occupied square or the board edge, otherwise moves one square outward.
// ----------------------------------------------------------------------------
module cbag_ray_cell (
  input  logic            clk,
  input  logic            rst,
  input  cbag_pkg::item_t prev,
  output cbag_pkg::item_t item
);

  cbag_pkg::item_t item_next;
  cbag_pkg::step_t nxt;

  always_comb begin
    item_next = prev;
    nxt       = '0;
    for (int d = 0; d < cbag_pkg::NUM_DIRS; d++) begin
      nxt = cbag_pkg::step_sq(prev.pos[d], cbag_pkg::dir_t'(3'(d)));
      if (prev.act[d]) begin
        item_next.attacks[prev.pos[d]] = 1'b1;
        item_next.act[d] = nxt.ok && !prev.occ[prev.pos[d]];
        item_next.pos[d] = nxt.sq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item.valid <= item_next.valid;
    end
    item.occ     <= item_next.occ;
    item.attacks <= item_next.attacks;
    item.act     <= item_next.act;
    item.pos     <= item_next.pos;
  end

endmodule

### rtl/chess_bitboard_attack_generator.sv
// ----------------------------------------------------------------------------
// chess_bitboard_attack_generator
// Attack set of a chess piece on a bitboard, one query per clock while busy is low.
// ----------------------------------------------------------------------------
// Usage:
//   A query is taken at a rising edge with start high and busy low. It
//   carries the piece kind (mode), the origin square (rank*8+file) and the
//   64-bit occupancy board. The attack set appears on attacks with done high
//   for exactly one cycle; the receiver has to take it in that cycle.
// Pipeline:
//   a query passes through one entry stage, loaded at the accepting edge, and
//   then seven ray cells, one cell per square of the longest ray. Throughput
//   is one query per cycle while busy is low; queries overlap in the
//   chain and results leave in the order queries came in.
// Reset:
//   rst clears all valid bits, so no stray done follows reset. busy is set
//   at each edge with rst high and cleared at each edge with rst low.
// Stalls:
//   there is no backpressure on results, so the chain never stalls.
// ----------------------------------------------------------------------------
module chess_bitboard_attack_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       mode,
  input  logic [cbag_pkg::SQ_W-1:0]        square,
  input  logic [cbag_pkg::BOARD_W-1:0]     occupancy,
  output logic                             done,
  output logic [cbag_pkg::BOARD_W-1:0]     attacks
);

  cbag_pkg::item_t chain [cbag_pkg::NUM_CELLS+1];
  logic            load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // a transfer happens whenever start meets a free block
  assign load = start && !busy;

  cbag_entry u_entry (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .mode      (mode),
    .square    (square),
    .occupancy (occupancy),
    .item      (chain[0])
  );

  for (genvar i = 0; i < cbag_pkg::NUM_CELLS; i++) begin : g_cell
    cbag_ray_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .prev (chain[i]),
      .item (chain[i+1])
    );
  end

  assign done    = chain[cbag_pkg::NUM_CELLS].valid;
  assign attacks = chain[cbag_pkg::NUM_CELLS].attacks;

endmodule

### test/tb_chess_bitboard_attack_generator.sv
// ----------------------------------------------------------------------------
// tb_chess_bitboard_attack_generator
// Drives attack-set queries for every piece kind, predicts each attack board
// with an independent ray walker and compares results in arrival order.
// ----------------------------------------------------------------------------
module tb_chess_bitboard_attack_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_QUERIES = 450;
  localparam int STALL_LIMIT    = 200;
  localparam int SETTLE_CYCLES  = 16;

  // expected attack boards, oldest first
  class attack_scoreboard;
    logic [63:0] pending_boards[$];
    int          mismatches;
    int          compared;
    int          queries;
    int          kind_count[8];

    function logic [63:0] attack_set(cbag_pkg::mode_t kind, logic [5:0] sq,
                                     logic [63:0] occ);
      logic [63:0] set;
      int          dr[8];
      int          df[8];
      int          dirs;
      int          reach;
      int          r;
      int          f;
      int          nr;
      int          nf;
      int          steps;
      set   = '0;
      r     = int'(sq[5:3]);
      f     = int'(sq[2:0]);
      dirs  = 0;
      reach = 1;
      dr    = '{0, 0, 0, 0, 0, 0, 0, 0};
      df    = '{0, 0, 0, 0, 0, 0, 0, 0};
      case (kind)
        cbag_pkg::MODE_WPAWN: begin
          dr   = '{-1, -1, 0, 0, 0, 0, 0, 0};
          df   = '{-1, 1, 0, 0, 0, 0, 0, 0};
          dirs = 2;
        end
        cbag_pkg::MODE_BPAWN: begin
          dr   = '{1, 1, 0, 0, 0, 0, 0, 0};
          df   = '{-1, 1, 0, 0, 0, 0, 0, 0};
          dirs = 2;
        end
        cbag_pkg::MODE_KNIGHT: begin
          dr   = '{2, 2, -2, -2, 1, 1, -1, -1};
          df   = '{1, -1, 1, -1, 2, -2, 2, -2};
          dirs = 8;
        end
        cbag_pkg::MODE_KING: begin
          dr   = '{1, 1, 1, 0, 0, -1, -1, -1};
          df   = '{-1, 0, 1, -1, 1, -1, 0, 1};
          dirs = 8;
        end
        cbag_pkg::MODE_BISHOP: begin
          dr    = '{1, 1, -1, -1, 0, 0, 0, 0};
          df    = '{1, -1, 1, -1, 0, 0, 0, 0};
          dirs  = 4;
          reach = 7;
        end
        cbag_pkg::MODE_ROOK: begin
          dr    = '{1, -1, 0, 0, 0, 0, 0, 0};
          df    = '{0, 0, 1, -1, 0, 0, 0, 0};
          dirs  = 4;
          reach = 7;
        end
        cbag_pkg::MODE_QUEEN: begin
          dr    = '{1, -1, 0, 0, 1, 1, -1, -1};
          df    = '{0, 0, 1, -1, 1, -1, 1, -1};
          dirs  = 8;
          reach = 7;
        end
        default: dirs = 0;
      endcase
      for (int d = 0; d < dirs; d++) begin
        nr    = r + dr[d];
        nf    = f + df[d];
        steps = 0;
        while (nr >= 0 && nr <= 7 && nf >= 0 && nf <= 7 && steps < reach) begin
          set[6'(nr * 8 + nf)] = 1'b1;
          // a ray ends on the first blocker, which is still attacked
          if (occ[6'(nr * 8 + nf)]) break;
          nr    = nr + dr[d];
          nf    = nf + df[d];
          steps = steps + 1;
        end
      end
      return set;
    endfunction

    function void note_query(cbag_pkg::mode_t kind, logic [5:0] sq, logic [63:0] occ);
      pending_boards.push_back(attack_set(kind, sq, occ));
      queries++;
      kind_count[kind]++;
    endfunction

    function void check_board(logic [63:0] got);
      logic [63:0] want;
      if (pending_boards.size() == 0) begin
        $display("%0t: result with no query waiting, actual %h", $time, got);
        mismatches++;
      end else begin
        want = pending_boards.pop_front();
        compared++;
        if (got !== want) begin
          $display("%0t: attacks mismatch, expected %h actual %h", $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  mode = cbag_pkg::MODE_WPAWN;
  logic [5:0]  square = '0;
  logic [63:0] occupancy = '0;
  logic        done;
  logic [63:0] attacks;

  attack_scoreboard attack_sb = new();
  int               quiet_cycles = 0;

  chess_bitboard_attack_generator DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .square    (square),
    .occupancy (occupancy),
    .done      (done),
    .attacks   (attacks)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transfer monitor and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        attack_sb.note_query(cbag_pkg::mode_t'(mode), square, occupancy);
      end
      if (done) begin
        attack_sb.check_board(attacks);
      end
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("tb_chess_bitboard_attack_generator NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // called at a rising edge, returns at the edge that takes the query
  task automatic issue_query(cbag_pkg::mode_t kind, logic [5:0] sq, logic [63:0] occ,
                             bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    mode      <= kind;
    square    <= sq;
    occupancy <= occ;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (attack_sb.pending_boards.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] random_board();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return a & b & c;
      3: return a & b;
      4: return a | b;
      default: return a;
    endcase
  endfunction

  function automatic cbag_pkg::mode_t random_kind();
    if ($urandom_range(0, 15) == 0) return cbag_pkg::MODE_NONE;
    return cbag_pkg::mode_t'($urandom_range(0, 6));
  endfunction

  initial begin
    bit burst;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // edges, corners, blockers and an occupied origin
    issue_query(cbag_pkg::MODE_WPAWN,  6'd0,  64'h0, 1'b0);
    issue_query(cbag_pkg::MODE_WPAWN,  6'd63, '1, 1'b0);
    issue_query(cbag_pkg::MODE_WPAWN,  6'd15, 64'h0, 1'b1);
    issue_query(cbag_pkg::MODE_BPAWN,  6'd63, '1, 1'b0);
    issue_query(cbag_pkg::MODE_BPAWN,  6'd0,  64'h0, 1'b0);
    issue_query(cbag_pkg::MODE_BPAWN,  6'd48, '1, 1'b1);
    issue_query(cbag_pkg::MODE_KNIGHT, 6'd0,  64'h0, 1'b0);
    issue_query(cbag_pkg::MODE_KNIGHT, 6'd27, '1, 1'b0);
    issue_query(cbag_pkg::MODE_KNIGHT, 6'd63, '1, 1'b1);
    issue_query(cbag_pkg::MODE_KING,   6'd7,  64'h0, 1'b0);
    issue_query(cbag_pkg::MODE_KING,   6'd36, '1, 1'b0);
    issue_query(cbag_pkg::MODE_BISHOP, 6'd27, 64'h0, 1'b0);
    issue_query(cbag_pkg::MODE_BISHOP, 6'd27, '1, 1'b1);
    issue_query(cbag_pkg::MODE_BISHOP, 6'd0,  64'h1, 1'b0);
    issue_query(cbag_pkg::MODE_ROOK,   6'd0,  64'h0, 1'b0);
    issue_query(cbag_pkg::MODE_ROOK,   6'd63, '1, 1'b0);
    issue_query(cbag_pkg::MODE_ROOK,   6'd36, 64'h1 << 36, 1'b1);
    issue_query(cbag_pkg::MODE_ROOK,   6'd0,  (64'h1 << 24) | (64'h1 << 3), 1'b0);
    issue_query(cbag_pkg::MODE_QUEEN,  6'd27, 64'h0, 1'b0);
    issue_query(cbag_pkg::MODE_QUEEN,  6'd56, '1, 1'b1);
    issue_query(cbag_pkg::MODE_QUEEN,  6'd35, 64'h0042_0000_1000_2400, 1'b0);
    issue_query(cbag_pkg::MODE_NONE,   6'd0,  64'h0, 1'b0);
    issue_query(cbag_pkg::MODE_NONE,   6'd63, '1, 1'b1);

    for (int i = 0; i < RANDOM_QUERIES; i++) begin
      // back-to-back stretches between randomly spaced ones
      burst = (i >= 100 && i < 160) || (i >= 300 && i < 350);
      if (i == 220) wait_drained();
      issue_query(random_kind(), 6'($urandom_range(0, 63)), random_board(), burst);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d queries (pawns %0d/%0d, knight %0d, king %0d, bishop %0d, rook %0d,",
             attack_sb.queries, attack_sb.kind_count[cbag_pkg::MODE_WPAWN],
             attack_sb.kind_count[cbag_pkg::MODE_BPAWN],
             attack_sb.kind_count[cbag_pkg::MODE_KNIGHT],
             attack_sb.kind_count[cbag_pkg::MODE_KING],
             attack_sb.kind_count[cbag_pkg::MODE_BISHOP],
             attack_sb.kind_count[cbag_pkg::MODE_ROOK]);
    $display("queen %0d, unused kind %0d), %0d attack boards compared, %0d mismatches",
             attack_sb.kind_count[cbag_pkg::MODE_QUEEN],
             attack_sb.kind_count[cbag_pkg::MODE_NONE],
             attack_sb.compared, attack_sb.mismatches);
    if (attack_sb.mismatches == 0 && attack_sb.pending_boards.size() == 0) begin
      $display("tb_chess_bitboard_attack_generator OK");
    end else begin
      $display("tb_chess_bitboard_attack_generator NOT OK");
    end
    $finish;
  end

endmodule
